[rtl/core/tcs_pkg.sv]
// tcs_pkg: types, register codes and constants for the torque command shaper
// no dependencies; used by tcs_divider.sv and torque_command_shaper.sv
package tcs_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivW    = 32;

  // ceil(2^44 / 100000), exact quotient for dividends below 2^27
  localparam logic [31:0] RampRecip = 32'd175921861;

  typedef enum logic [2:0] {
    REG_REGEN_ENGAGE  = 3'd0,
    REG_REGEN_RELEASE = 3'd1,
    REG_POWER_ENGAGE  = 3'd2,
    REG_POWER_RELEASE = 3'd3,
    REG_CROSSOVER     = 3'd4,
    REG_GEAR_HOLD     = 3'd5,
    REG_GEAR_RAMP     = 3'd6,
    REG_DEADBAND      = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE          = 3'd0,
    KIND_REGEN_ENGAGE  = 3'd1,
    KIND_REGEN_RELEASE = 3'd2,
    KIND_POWER_ENGAGE  = 3'd3,
    KIND_POWER_RELEASE = 3'd4,
    KIND_REGEN_TO_PWR  = 3'd5,
    KIND_PWR_TO_REGEN  = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_PDIV,
    ST_PWAIT,
    ST_CURVE,
    ST_SCALE,
    ST_GEAR,
    ST_GMUL,
    ST_GDIV,
    ST_GWAIT,
    ST_DBAND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [10:0] target_torque;
    logic [1:0]         gear;
    logic [31:0]        time_ms;
    logic               clear;
  } in_word_t;

  typedef struct packed {
    logic signed [10:0] torque_out;
    logic               drive_enable;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [47:0]     dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/tcs_divider.sv]
// tcs_divider: restoring divider, one quotient bit per cycle
// depends on tcs_pkg (request and response structs)
module tcs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcs_pkg::div_req_t req_i,
  output tcs_pkg::div_rsp_t rsp_o
);

  logic [47:0] num_q, num_d;
  logic [48:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;

  // one shift-subtract step per cycle
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[47:0], num_q[47]};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[46:0], 1'b0};
      if (trial >= {17'd0, den_q}) begin
        rem_d    = trial - {17'd0, den_q};
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = num_q[31:0];

endmodule

[rtl/core/torque_command_shaper.sv]
// torque_command_shaper: top level, register file, sequencer and shared multiplier
// depends on tcs_pkg and tcs_divider
//
// Shapes one signed torque command per control tick.
// Input channel in_valid_i / in_stall_o carries a tcs_pkg::in_word_t word;
// output channel out_valid_o / out_stall_i carries a tcs_pkg::out_word_t word.
// in_stall_o is high while a word is being worked on or its result waits.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// writes are taken at any time, unknown indexes are dropped.
// A clear word goes from the shape step straight to the output; any other
// word passes the gear and deadband steps. A word still inside a transition
// first takes the progress division and the curve and scale steps, and a gear
// ramp adds the ramp multiply steps. The time a word takes is set by the
// 48-step serial divider for the progress quotient, plus the one 32x32
// multiplier used in turn for curve, scale and ramp steps (the ramp division
// by 100000 is a reciprocal multiplication). A new word is taken only after
// the result of the last one has left the output register.
// At reset the registers take their default values and all shaping state is
// zero. When the receiver stalls the result holds in the output register
// and no new word is taken until it leaves.
module torque_command_shaper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcs_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcs_pkg::out_word_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcs_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  // register file
  logic [12:0] regen_eng_q, regen_rel_q, power_eng_q, power_rel_q, cross_q, hold_q;
  logic [16:0] ramp_q;
  logic [7:0]  dband_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regen_eng_q <= 13'd300;
      regen_rel_q <= 13'd150;
      power_eng_q <= 13'd200;
      power_rel_q <= 13'd100;
      cross_q     <= 13'd400;
      hold_q      <= 13'd200;
      ramp_q      <= 17'd100;
      dband_q     <= 8'd20;
    end else if (cfg_valid_i) begin
      case (tcs_pkg::reg_idx_e'(cfg_index_i))
        tcs_pkg::REG_REGEN_ENGAGE:  regen_eng_q <= cfg_data_i[12:0];
        tcs_pkg::REG_REGEN_RELEASE: regen_rel_q <= cfg_data_i[12:0];
        tcs_pkg::REG_POWER_ENGAGE:  power_eng_q <= cfg_data_i[12:0];
        tcs_pkg::REG_POWER_RELEASE: power_rel_q <= cfg_data_i[12:0];
        tcs_pkg::REG_CROSSOVER:     cross_q     <= cfg_data_i[12:0];
        tcs_pkg::REG_GEAR_HOLD:     hold_q      <= cfg_data_i[12:0];
        tcs_pkg::REG_GEAR_RAMP:     ramp_q      <= cfg_data_i[16:0];
        tcs_pkg::REG_DEADBAND:      dband_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // shaping state
  tcs_pkg::state_e state_q, state_d;
  logic signed [10:0] last_q, last_d, sstart_q, sstart_d;
  tcs_pkg::kind_e kind_q, kind_d;
  logic [31:0] tstart_q, tstart_d, gstart_q, gstart_d;
  logic        ghold_q, ghold_d, indb_q, indb_d;
  logic [1:0]  pgear_q, pgear_d;
  // working registers
  tcs_pkg::in_word_t in_q, in_d;
  logic signed [11:0] y_q, y_d;
  logic [31:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [12:0] tsel_q, tsel_d;
  tcs_pkg::out_word_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  tcs_pkg::div_req_t div_req;
  tcs_pkg::div_rsp_t div_rsp;

  tcs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  function automatic tcs_pkg::kind_e classify(input logic signed [11:0] c,
                                              input logic signed [11:0] t);
    logic cz, cp, cn, tz, tp, tn;
    cz = (c > -12'sd10) && (c < 12'sd10);
    cp = c > 12'sd10;
    cn = c < -12'sd10;
    tz = (t > -12'sd10) && (t < 12'sd10);
    tp = t > 12'sd10;
    tn = t < -12'sd10;
    if (cz && tn)      classify = tcs_pkg::KIND_REGEN_ENGAGE;
    else if (cn && tz) classify = tcs_pkg::KIND_REGEN_RELEASE;
    else if (cz && tp) classify = tcs_pkg::KIND_POWER_ENGAGE;
    else if (cp && tz) classify = tcs_pkg::KIND_POWER_RELEASE;
    else if (cn && tp) classify = tcs_pkg::KIND_REGEN_TO_PWR;
    else if (cp && tn) classify = tcs_pkg::KIND_PWR_TO_REGEN;
    else if (cn && tn) classify = tcs_pkg::KIND_REGEN_ENGAGE;
    else if (cp && tp) classify = tcs_pkg::KIND_POWER_ENGAGE;
    else               classify = tcs_pkg::KIND_NONE;
  endfunction

  logic signed [11:0] tgt_w, last_w, delta_w, y_abs;
  logic [11:0] delta_mag;
  tcs_pkg::kind_e kind_new;
  logic [12:0] tsel_w;
  logic [31:0] elapsed_w, gel_w;
  logic [31:0] q_w;
  logic signed [12:0] ysum;

  assign tgt_w   = 12'(in_q.target_torque);
  assign last_w  = 12'(last_q);
  assign delta_w = 12'(in_q.target_torque) - 12'(sstart_q);
  assign delta_mag = delta_w[11] ? 12'(-delta_w) : delta_w;
  assign y_abs   = y_q[11] ? -y_q : y_q;
  assign elapsed_w = in_q.time_ms - tstart_q;
  assign gel_w     = in_q.time_ms - gstart_q;
  assign q_w       = 32'd65536 - acc_q;

  // sequencer: next state and datapath
  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    sstart_d    = sstart_q;
    kind_d      = kind_q;
    tstart_d    = tstart_q;
    gstart_d    = gstart_q;
    ghold_d     = ghold_q;
    indb_d      = indb_q;
    pgear_d     = pgear_q;
    in_d        = in_q;
    y_d         = y_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    tsel_d      = tsel_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_req     = '0;
    mul_a       = '0;
    mul_b       = '0;
    kind_new    = kind_q;
    tsel_w      = '0;
    ysum        = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tcs_pkg::ST_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          in_d    = in_data_i;
          state_d = tcs_pkg::ST_SHAPE;
        end
      end
      // clear handling, transition classification and progress division launch
      tcs_pkg::ST_SHAPE: begin
        if (in_q.clear) begin
          last_d  = '0;
          kind_d  = tcs_pkg::KIND_NONE;
          ghold_d = 1'b0;
          indb_d  = 1'b0;
          out_d   = '0;
          state_d = tcs_pkg::ST_OUT;
        end else if (tgt_w == last_w) begin
          kind_d  = tcs_pkg::KIND_NONE;
          y_d     = tgt_w;
          state_d = tcs_pkg::ST_GEAR;
        end else begin
          if (kind_q == tcs_pkg::KIND_NONE) begin
            kind_new = classify(last_w, tgt_w);
            sstart_d = last_q;
            tstart_d = in_q.time_ms;
          end
          case (kind_new)
            tcs_pkg::KIND_REGEN_ENGAGE:  tsel_w = regen_eng_q;
            tcs_pkg::KIND_REGEN_RELEASE: tsel_w = regen_rel_q;
            tcs_pkg::KIND_POWER_ENGAGE:  tsel_w = power_eng_q;
            tcs_pkg::KIND_POWER_RELEASE: tsel_w = power_rel_q;
            tcs_pkg::KIND_REGEN_TO_PWR,
            tcs_pkg::KIND_PWR_TO_REGEN:  tsel_w = cross_q;
            default:                     tsel_w = '0;
          endcase
          kind_d = kind_new;
          tsel_d = tsel_w;
          y_d    = tgt_w;
          if (tsel_w == '0) begin
            kind_d  = tcs_pkg::KIND_NONE;
            state_d = tcs_pkg::ST_GEAR;
          end else begin
            state_d = tcs_pkg::ST_PDIV;
          end
        end
      end
      tcs_pkg::ST_PDIV: begin
        if (elapsed_w >= {19'd0, tsel_q}) begin
          kind_d  = tcs_pkg::KIND_NONE;
          state_d = tcs_pkg::ST_GEAR;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {elapsed_w, 16'd0};
          div_req.divisor  = {19'd0, tsel_q};
          state_d = tcs_pkg::ST_PWAIT;
        end
      end
      tcs_pkg::ST_PWAIT: begin
        if (!div_rsp.busy) begin
          acc_d   = div_rsp.quotient;
          state_d = tcs_pkg::ST_CURVE;
        end
      end
      // ease-in-out curve, 2*p^2 below one half, else 1 - 2*(1-p)^2
      tcs_pkg::ST_CURVE: begin
        if (acc_q < 32'd32768) begin
          mul_a = acc_q;
          mul_b = acc_q;
          acc_d = 32'(mul_p >> 15);
        end else begin
          mul_a = q_w;
          mul_b = q_w;
          acc_d = 32'd65536 - 32'(mul_p >> 15);
        end
        state_d = tcs_pkg::ST_SCALE;
      end
      tcs_pkg::ST_SCALE: begin
        mul_a = {20'd0, delta_mag};
        mul_b = acc_q;
        prod_d = (mul_p + 64'd32768) >> 16;
        if (delta_w[11]) begin
          y_d = 12'(sstart_q) - 12'(mul_p[43:16] + {27'd0, mul_p[15]});
        end else begin
          y_d = 12'(sstart_q) + 12'(mul_p[43:16] + {27'd0, mul_p[15]});
        end
        state_d = tcs_pkg::ST_GEAR;
      end
      // gear change hold and ramp
      tcs_pkg::ST_GEAR: begin
        pgear_d = in_q.gear;
        if (pgear_q != in_q.gear && pgear_q != 2'd0) begin
          ghold_d  = 1'b1;
          gstart_d = in_q.time_ms;
          y_d      = '0;
          state_d  = tcs_pkg::ST_DBAND;
          if (hold_q == '0) begin
            state_d = tcs_pkg::ST_GMUL;
            acc_d   = 32'd0;
          end
        end else if (!ghold_q) begin
          state_d = tcs_pkg::ST_DBAND;
        end else if (gel_w < {19'd0, hold_q}) begin
          y_d     = '0;
          state_d = tcs_pkg::ST_DBAND;
        end else begin
          acc_d   = gel_w - {19'd0, hold_q};
          state_d = tcs_pkg::ST_GMUL;
        end
      end
      tcs_pkg::ST_GMUL: begin
        mul_a  = acc_q;
        mul_b  = {15'd0, ramp_q};
        prod_d = mul_p;
        if (mul_p >= 64'd100000) begin
          ghold_d = 1'b0;
          state_d = tcs_pkg::ST_DBAND;
        end else begin
          state_d = tcs_pkg::ST_GDIV;
        end
      end
      // rounded ramp product, below 2^27
      tcs_pkg::ST_GDIV: begin
        mul_a  = {20'd0, y_abs};
        mul_b  = prod_q[31:0];
        prod_d = mul_p + 64'd50000;
        state_d = tcs_pkg::ST_GWAIT;
      end
      // divide by 100000 through the reciprocal, quotient is bits 55:44
      tcs_pkg::ST_GWAIT: begin
        mul_a = prod_q[31:0];
        mul_b = tcs_pkg::RampRecip;
        ysum  = 13'(mul_p[55:44]);
        y_d   = y_q[11] ? 12'(-ysum) : 12'(ysum);
        state_d = tcs_pkg::ST_DBAND;
      end
      // deadband with hysteresis
      tcs_pkg::ST_DBAND: begin
        if (indb_q) begin
          if ({1'b0, y_abs[10:0]} > 12'(dband_q) + 12'd10) begin
            indb_d = 1'b0;
          end else begin
            y_d = '0;
          end
        end else if (y_abs[10:0] < 11'(dband_q)) begin
          indb_d = 1'b1;
          y_d    = '0;
        end
        state_d = tcs_pkg::ST_OUT;
      end
      tcs_pkg::ST_OUT: begin
        if (!in_q.clear) begin
          last_d = y_q[10:0];
          out_d.torque_out   = y_q[10:0];
          out_d.drive_enable = y_abs > 12'sd5;
        end
        out_valid_d = 1'b1;
        state_d = tcs_pkg::ST_IDLE;
      end
      default: state_d = tcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcs_pkg::ST_IDLE;
      last_q      <= '0;
      sstart_q    <= '0;
      kind_q      <= tcs_pkg::KIND_NONE;
      tstart_q    <= '0;
      gstart_q    <= '0;
      ghold_q     <= 1'b0;
      indb_q      <= 1'b0;
      pgear_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      sstart_q    <= sstart_d;
      kind_q      <= kind_d;
      tstart_q    <= tstart_d;
      gstart_q    <= gstart_d;
      ghold_q     <= ghold_d;
      indb_q      <= indb_d;
      pgear_q     <= pgear_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    tsel_q <= tsel_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != tcs_pkg::ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
